// File: rtl/assert_macros.svh
// Assertion helpers for clocked checks under the block reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define SIT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sit assertion failed");

// Implication checked on the following edge.
`define SIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sit assertion failed");

`endif

// File: rtl/sit_pkg.sv
package sit_pkg;

    localparam int MAX_NAME_BYTES_DEF   = 32;
    localparam int STORE_BYTES_DEF      = 4096;
    localparam int MAX_USER_SYMBOLS_DEF = 256;

    localparam int ROM_COUNT   = 53;
    localparam int ROM_BYTES   = 8;
    localparam int FETCH_LIMIT = 32;

    localparam logic ACT_INTERN = 1'b0;
    localparam logic ACT_FETCH  = 1'b1;

    typedef enum logic [2:0] {
        ST_BUILTIN   = 3'd0,
        ST_USER      = 3'd1,
        ST_ADDED     = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_WORD  = 3'd4,
        ST_NAME_BYTE = 3'd5,
        ST_BAD_INDEX = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROM,
        S_ROMCHK,
        S_UWALK,
        S_ULEN,
        S_UCMP,
        S_UCHK,
        S_APP,
        S_FROM,
        S_FWALK,
        S_FSKIP,
        S_FLEN,
        S_FRD,
        S_FOUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [8:0] idx;
        t_status    status;
        logic [7:0] nbyte;
        logic       fin;
    } t_res;

    typedef struct packed {
        logic word_in;     // shift a new byte in at cell 0
        logic word_drain;  // shift toward cell 0, zero at the top
        logic probe_shift; // shift a store byte in at cell 0
        logic probe_load;  // load every probe cell in parallel
    } t_cell_ctl;

    // Builtin names, right-justified: the last byte sits in the low bits, so
    // byte k of the value is byte len-1-k of the name.
    function automatic logic [ROM_BYTES*8-1:0] rom_bits(input logic [5:0] i);
        logic [ROM_BYTES*8-1:0] s;
        s = '0;
        unique case (i)
            6'd0:  s = 64'("nil");
            6'd1:  s = 64'("true");
            6'd2:  s = 64'("false");
            6'd3:  s = 64'("def");
            6'd4:  s = 64'("set");
            6'd5:  s = 64'(".");
            6'd6:  s = 64'("index");
            6'd7:  s = 64'("lambda");
            6'd8:  s = 64'h0000_0000_0000_CEBB;
            6'd9:  s = 64'("if");
            6'd10: s = 64'("unless");
            6'd11: s = 64'("?");
            6'd12: s = 64'("and");
            6'd13: s = 64'("or");
            6'd14: s = 64'("not");
            6'd15: s = 64'("print");
            6'd16: s = 64'("list");
            6'd17: s = 64'("read");
            6'd18: s = 64'("write");
            6'd19: s = 64'("exec");
            6'd20: s = 64'("escape");
            6'd21: s = 64'("sleep");
            6'd22: s = 64'("macro");
            6'd23: s = 64'("concat");
            6'd24: s = 64'("flat");
            6'd25: s = 64'("join");
            6'd26: s = 64'("shuffle");
            6'd27: s = 64'("for");
            6'd28: s = 64'("for*");
            6'd29: s = 64'("map");
            6'd30: s = 64'("map*");
            6'd31: s = 64'("i-map");
            6'd32: s = 64'("i-map*");
            6'd33: s = 64'("iter");
            6'd34: s = 64'("reduce");
            6'd35: s = 64'("while");
            6'd36: s = 64'("do");
            6'd37: s = 64'("+");
            6'd38: s = 64'("-");
            6'd39: s = 64'("*");
            6'd40: s = 64'h0000_0000_0000_C397;
            6'd41: s = 64'("/");
            6'd42: s = 64'h0000_0000_0000_C3B7;
            6'd43: s = 64'("%");
            6'd44: s = 64'("<");
            6'd45: s = 64'("<=");
            6'd46: s = 64'h0000_0000_00E2_89A4;
            6'd47: s = 64'(">");
            6'd48: s = 64'(">=");
            6'd49: s = 64'h0000_0000_00E2_89A5;
            6'd50: s = 64'("=");
            6'd51: s = 64'("!=");
            6'd52: s = 64'h0000_0000_00E2_89A0;
            default: s = '0;
        endcase
        return s;
    endfunction

    // No builtin name holds a zero byte, so the length is one past the top nonzero byte.
    function automatic logic [3:0] rom_len(input logic [5:0] i);
        logic [ROM_BYTES*8-1:0] s;
        logic [3:0]             n;
        s = rom_bits(i);
        n = '0;
        for (int k = 0; k < ROM_BYTES; k++) begin
            if (s[k*8 +: 8] != 8'h00) n = 4'(k + 1);
        end
        return n;
    endfunction

endpackage

// File: rtl/symbol_interning_table_core.sv
// Symbol interning table. Word bytes enter one per beat on the slave side
// (tuser low = intern byte, tlast marks the final byte); a word's bytes sit in
// a chain of byte cells and are matched first against 53 builtin names
// (index 0..52), then against the packed user store (indices -1, -2, ... in
// order of addition). A word that matches nothing is appended and gets the
// next negative index. An over-long word gives status bad word, a full store
// gives store full. Middle bytes give no beat. A fetch beat (tuser high)
// streams the named bytes back, one result beat per byte, the last with
// tlast; for a user name the store is walked to the name, and each byte is
// read through the single registered store read port before it is returned.
// Input is held off (s_tready low) while a word walk or a fetch runs; one
// finished result may wait in the output register meanwhile. The store needs
// no clearing after reset: only bytes already written are ever used.
`include "assert_macros.svh"

module symbol_interning_table_core
    import sit_pkg::*;
#(
    parameter int MAX_NAME_BYTES   = MAX_NAME_BYTES_DEF,
    parameter int STORE_BYTES      = STORE_BYTES_DEF,
    parameter int MAX_USER_SYMBOLS = MAX_USER_SYMBOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // word_byte[7:0], symbol_index[16:8], zero pad
    input  logic        i_s_tuser,  // action
    input  logic        i_s_tlast,  // word_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // result_index[8:0], name_byte[16:9], zero pad
    output logic [2:0]  o_m_tuser,  // status
    output logic        o_m_tlast   // final_res
);

    localparam int N  = MAX_NAME_BYTES;
    localparam int LW = $clog2(N + 1);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = AW + 1;
    localparam int UW = $clog2(MAX_USER_SYMBOLS + 1);
    localparam int CW = $clog2((N > FETCH_LIMIT ? N : FETCH_LIMIT) + 1);

    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_ovf, n_ovf;
    logic [PW-1:0]   r_fill, n_fill;
    logic [UW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_pos, n_pos;
    logic [UW-1:0]   r_k, n_k;
    logic [UW-1:0]   r_target, n_target;
    logic [7:0]      r_l, n_l;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [5:0]      r_rom_i, n_rom_i;
    logic [8:0]      r_fidx, n_fidx;
    t_res            r_pend, n_pend;
    t_res            r_out, n_out;
    logic            r_ovalid, n_ovalid;

    logic [7:0]      mem [STORE_BYTES];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   raddr, waddr;
    logic [7:0]      wdata;
    logic            we;

    t_cell_ctl       ctl;
    logic [7:0]      words  [N];
    logic [7:0]      probes [N];
    logic [N-1:0]    hits;
    logic            all_hit;
    logic [ROM_BYTES*8-1:0] rom_vec;
    logic [ROM_BYTES*8-1:0] fetch_vec;

    logic            s_acc;
    logic            out_free;
    logic            emit;
    t_res            emit_res;
    logic [8:0]      in_idx;
    logic [7:0]      in_byte;
    logic [31:0]     k32, cnt32, cnt_next32;
    logic [3:0]      flen;
    int              mag;

    assign in_byte  = i_s_tdata[7:0];
    assign in_idx   = i_s_tdata[16:8];
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;
    assign all_hit  = &hits;
    assign rom_vec  = rom_bits(r_rom_i);
    assign fetch_vec = rom_bits(r_fidx[5:0]);
    assign k32      = 32'(r_k);
    assign cnt32    = 32'(r_cnt);
    assign cnt_next32 = cnt32 + 32'd1;
    assign mag      = -int'($signed(in_idx));
    assign flen     = rom_len(r_fidx[5:0]);

    // Word and probe chain: cell 0 takes the newest byte.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [7:0] wprev, wnext, pprev, pld;
        if (g == 0) begin : g_head
            assign wprev = in_byte;
            assign pprev = r_rdata;
        end else begin : g_body
            assign wprev = words[g-1];
            assign pprev = probes[g-1];
        end
        if (g == N - 1) begin : g_top
            assign wnext = 8'h00;
        end else begin : g_below
            assign wnext = words[g+1];
        end
        if (g < ROM_BYTES) begin : g_rom
            assign pld = rom_vec[g*8 +: 8];
        end else begin : g_norom
            assign pld = 8'h00;
        end
        sit_cell #(.IDX(g), .LW(LW)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_word_prev (wprev),
            .i_word_next (wnext),
            .i_probe_prev(pprev),
            .i_probe_ld  (pld),
            .i_len       (r_len),
            .o_word      (words[g]),
            .o_probe     (probes[g]),
            .o_hit       (hits[g])
        );
    end

    // User name store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_fill   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_target <= n_target;
        r_l      <= n_l;
        r_cnt    <= n_cnt;
        r_rom_i  <= n_rom_i;
        r_fidx   <= n_fidx;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_fill   = r_fill;
        n_count  = r_count;
        n_pos    = r_pos;
        n_k      = r_k;
        n_target = r_target;
        n_l      = r_l;
        n_cnt    = r_cnt;
        n_rom_i  = r_rom_i;
        n_fidx   = r_fidx;
        n_pend   = r_pend;
        ctl      = '0;
        we       = 1'b0;
        waddr    = r_fill[AW-1:0];
        wdata    = 8'(r_len);
        raddr    = r_pos[AW-1:0];
        emit     = 1'b0;
        emit_res = r_pend;
        o_s_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (s_acc && i_s_tuser == ACT_INTERN) begin
                    // drop bytes past the buffer, remember the overflow
                    if (int'(r_len) < N) begin
                        ctl.word_in = 1'b1;
                        n_len = r_len + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        if (r_ovf || int'(r_len) >= N) begin
                            n_pend  = '{idx: 9'd0, status: ST_BAD_WORD, nbyte: 8'd0, fin: 1'b1};
                            n_len   = '0;
                            n_ovf   = 1'b0;
                            n_state = S_EMIT;
                        end else begin
                            n_rom_i = '0;
                            n_state = S_ROM;
                        end
                    end
                end else if (s_acc) begin
                    n_fidx = in_idx;
                    n_cnt  = '0;
                    n_pos  = '0;
                    n_k    = '0;
                    if (!in_idx[8] && int'(in_idx) < ROM_COUNT) begin
                        n_state = S_FROM;
                    end else if (in_idx[8] && mag <= int'(r_count)) begin
                        n_target = UW'(mag - 1);
                        n_state  = S_FWALK;
                    end else begin
                        n_pend  = '{idx: in_idx, status: ST_BAD_INDEX, nbyte: 8'd0, fin: 1'b1};
                        n_state = S_EMIT;
                    end
                end
            end

            S_ROM: begin
                ctl.probe_load = 1'b1;
                n_state = S_ROMCHK;
            end

            S_ROMCHK: begin
                if (32'(rom_len(r_rom_i)) == 32'(r_len) && all_hit) begin
                    n_pend  = '{idx: 9'(r_rom_i), status: ST_BUILTIN, nbyte: 8'd0, fin: 1'b1};
                    n_len   = '0;
                    n_state = S_EMIT;
                end else if (int'(r_rom_i) == ROM_COUNT - 1) begin
                    n_pos   = '0;
                    n_k     = '0;
                    n_state = S_UWALK;
                end else begin
                    n_rom_i = r_rom_i + 6'd1;
                    n_state = S_ROM;
                end
            end

            S_UWALK: begin
                // raddr = r_pos fetches the next length byte
                if (r_k == r_count) begin
                    if (int'(r_count) >= MAX_USER_SYMBOLS
                        || 32'(r_fill) + 32'd1 + 32'(r_len) > 32'(STORE_BYTES)) begin
                        n_pend  = '{idx: 9'd0, status: ST_FULL, nbyte: 8'd0, fin: 1'b1};
                        n_len   = '0;
                        n_state = S_EMIT;
                    end else begin
                        we      = 1'b1;
                        n_cnt   = '0;
                        n_state = S_APP;
                    end
                end else begin
                    n_state = S_ULEN;
                end
            end

            S_ULEN: begin
                n_l = r_rdata;
                if (32'(r_rdata) == 32'(r_len)) begin
                    raddr   = AW'(r_pos + PW'(1));
                    n_cnt   = '0;
                    n_state = S_UCMP;
                end else begin
                    n_pos   = r_pos + PW'(1) + PW'(r_rdata);
                    n_k     = r_k + UW'(1);
                    n_state = S_UWALK;
                end
            end

            S_UCMP: begin
                // r_rdata holds name byte r_cnt
                ctl.probe_shift = 1'b1;
                raddr = AW'(r_pos + PW'(2) + PW'(r_cnt));
                if (cnt_next32 < 32'(r_l)) begin
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    n_state = S_UCHK;
                end
            end

            S_UCHK: begin
                if (all_hit) begin
                    n_pend  = '{idx: ~k32[8:0], status: ST_USER, nbyte: 8'd0, fin: 1'b1};
                    n_len   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_pos   = r_pos + PW'(1) + PW'(r_l);
                    n_k     = r_k + UW'(1);
                    n_state = S_UWALK;
                end
            end

            S_APP: begin
                // cell 0 holds the last unwritten byte; write back to front
                we = 1'b1;
                waddr = AW'(r_fill + PW'(r_len) - PW'(r_cnt));
                wdata = words[0];
                ctl.word_drain = 1'b1;
                if (cnt_next32 == 32'(r_len)) begin
                    n_fill  = r_fill + PW'(1) + PW'(r_len);
                    n_count = r_count + UW'(1);
                    n_pend  = '{idx: ~(9'(r_count)), status: ST_ADDED, nbyte: 8'd0, fin: 1'b1};
                    n_len   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            S_FROM: begin
                emit_res = '{idx: r_fidx, status: ST_NAME_BYTE,
                             nbyte: fetch_vec[(32'(flen) - 32'd1 - cnt32)*8 +: 8],
                             fin: cnt_next32 == 32'(flen)};
                if (out_free) begin
                    emit = 1'b1;
                    if (cnt_next32 == 32'(flen)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end

            S_FWALK: begin
                n_state = (r_k == r_target) ? S_FLEN : S_FSKIP;
            end

            S_FSKIP: begin
                n_pos   = r_pos + PW'(1) + PW'(r_rdata);
                n_k     = r_k + UW'(1);
                n_state = S_FWALK;
            end

            S_FLEN: begin
                n_l = (32'(r_rdata) > 32'(FETCH_LIMIT)) ? 8'(FETCH_LIMIT) : r_rdata;
                n_cnt = '0;
                if (r_rdata == 8'd0) begin
                    n_pend  = '{idx: r_fidx, status: ST_BAD_INDEX, nbyte: 8'd0, fin: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FRD;
                end
            end

            S_FRD: begin
                raddr   = AW'(r_pos + PW'(1) + PW'(r_cnt));
                n_state = S_FOUT;
            end

            S_FOUT: begin
                // hold the address so the read data stays put under a stall
                raddr    = AW'(r_pos + PW'(1) + PW'(r_cnt));
                emit_res = '{idx: r_fidx, status: ST_NAME_BYTE, nbyte: r_rdata,
                             fin: cnt_next32 == 32'(r_l)};
                if (out_free) begin
                    emit = 1'b1;
                    if (cnt_next32 == 32'(r_l)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_FRD;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Output register: load a result when the slot is empty or being drained.
    always_comb begin
        n_ovalid = r_ovalid && !i_m_tready;
        n_out    = r_out;
        if (emit) begin
            n_ovalid = 1'b1;
            n_out    = emit_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_out.nbyte, r_out.idx};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.fin;

    `SIT_ASSERT_IMPL(a_fill_count, 1'b1, (r_count == '0) == (r_fill == '0))
    `SIT_ASSERT_IMPL(a_len_bound, 1'b1, int'(r_len) <= N)
    `SIT_ASSERT_IMPL(a_walk_word, r_state == S_ROM || r_state == S_APP, r_len != '0)
    `SIT_ASSERT_NEXT(a_emit_shows, emit, o_m_tvalid)

endmodule

// File: rtl/sit_cell.sv
module sit_cell
    import sit_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 6
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [7:0]    i_word_prev,
    input  logic [7:0]    i_word_next,
    input  logic [7:0]    i_probe_prev,
    input  logic [7:0]    i_probe_ld,
    input  logic [LW-1:0] i_len,
    output logic [7:0]    o_word,
    output logic [7:0]    o_probe,
    output logic          o_hit
);

    logic [7:0] r_word;
    logic [7:0] r_probe;

    always_ff @(posedge i_clk) begin
        if (i_ctl.word_in) begin
            r_word <= i_word_prev;
        end else if (i_ctl.word_drain) begin
            r_word <= i_word_next;
        end
        if (i_ctl.probe_load) begin
            r_probe <= i_probe_ld;
        end else if (i_ctl.probe_shift) begin
            r_probe <= i_probe_prev;
        end
    end

    assign o_word  = r_word;
    assign o_probe = r_probe;
    // cells past the word length never veto a match
    assign o_hit   = (r_word == r_probe) || (IDX >= int'(i_len));

endmodule
